// File: rtl/core/spbp_pkg.sv
// Shared types, constants and helper functions of the sphere pair broad phase.
`default_nettype none
package spbp_pkg;

  localparam int COORD_W   = 32;
  localparam int RAD_W     = 31;
  localparam int NRM_W     = 16;
  localparam int IDX_OUT_W = 3;
  localparam int QUO_W     = 15;
  localparam logic [QUO_W-1:0] NORM_ONE = 15'd16384;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [RAD_W-1:0]          r;
    logic                      part;
  } body_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic ld_out;
    logic out_end;
    logic q_pop;
  } back_ctl_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_READ,
    BK_DIFF,
    BK_MUL,
    BK_ACC,
    BK_TEST,
    BK_SQRT,
    BK_DIVI,
    BK_DIV,
    BK_EMIT,
    BK_NEXT,
    BK_CLOSE
  } back_state_t;

  // Magnitude of a coordinate difference; never reaches 2^32.
  function automatic logic [COORD_W-1:0] mag33(logic signed [COORD_W:0] v);
    logic [COORD_W:0] n;
    n = 33'd0 - v;
    return v[COORD_W] ? n[COORD_W-1:0] : v[COORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/spbp_ram.sv
// Generic single-write, dual-read memory with registered read data.
`default_nettype none
module spbp_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// File: rtl/core/spbp_queue.sv
// Small register FIFO carrying run commands from the front end to the back end.
`default_nettype none
module spbp_queue
  import spbp_pkg::*;
#(
  parameter int WIDTH = 5,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] head,
  output q_stat_t               stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  function automatic logic [PW-1:0] inc(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head       = slot_r[rp_r];
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wp_nxt  = push ? inc(wp_r) : wp_r;
    rp_nxt  = pop ? inc(rp_r) : rp_r;
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/spbp_front.sv
// Front end: accepts bodies, stores them in the current bank and posts runs.
`default_nettype none
module spbp_front
  import spbp_pkg::*;
#(
  parameter int MAX_BODIES = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [COORD_W-1:0]         in_pos_x,
  input  wire logic signed [COORD_W-1:0]         in_pos_y,
  input  wire logic signed [COORD_W-1:0]         in_pos_z,
  input  wire logic [RAD_W-1:0]                  in_bound_radius,
  input  wire logic                              in_is_rigid,
  input  wire logic                              in_collidable,
  input  wire logic                              in_last_body,
  output logic                                   ram_we,
  output logic [$clog2(2*MAX_BODIES)-1:0]        ram_waddr,
  output body_t                                  ram_wdata,
  output logic                                   q_push,
  output logic [$clog2(MAX_BODIES+1):0]          q_data,
  input  wire q_stat_t                           q_stat
);

  localparam int CW = $clog2(MAX_BODIES + 1);
  localparam int IW = $clog2(MAX_BODIES);

  logic [CW-1:0] cnt_r, cnt_nxt, stored;
  logic          bank_r, bank_nxt;
  logic          take;

  assign in_ready  = !q_stat.full;
  assign take      = in_valid && in_ready;
  assign ram_we    = take && (cnt_r != CW'(MAX_BODIES));
  assign ram_waddr = {bank_r, cnt_r[IW-1:0]};
  assign ram_wdata = '{x: in_pos_x, y: in_pos_y, z: in_pos_z, r: in_bound_radius,
                       part: in_is_rigid && in_collidable};
  assign stored    = cnt_r + CW'(ram_we);
  assign q_push    = take && in_last_body;
  assign q_data    = {bank_r, stored};

  always_comb begin
    cnt_nxt  = q_push ? '0 : stored;
    bank_nxt = q_push ? !bank_r : bank_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      bank_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      bank_r <= bank_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/spbp_back.sv
// Back end: walks the pairs of one run, tests them and builds contact results.
`default_nettype none
module spbp_back
  import spbp_pkg::*;
#(
  parameter int MAX_BODIES = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [$clog2(MAX_BODIES+1):0] q_head,
  input  wire q_stat_t                       q_stat,
  output logic                               q_pop,
  output logic [$clog2(2*MAX_BODIES)-1:0]    raddr_a,
  output logic [$clog2(2*MAX_BODIES)-1:0]    raddr_b,
  input  wire body_t                         rdata_a,
  input  wire body_t                         rdata_b,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_contact_valid,
  output logic [IDX_OUT_W-1:0]               out_first_index,
  output logic [IDX_OUT_W-1:0]               out_second_index,
  output logic signed [COORD_W-1:0]          out_point_x,
  output logic signed [COORD_W-1:0]          out_point_y,
  output logic signed [COORD_W-1:0]          out_point_z,
  output logic signed [NRM_W-1:0]            out_normal_x,
  output logic signed [NRM_W-1:0]            out_normal_y,
  output logic signed [NRM_W-1:0]            out_normal_z,
  output logic                               out_coincident,
  output logic                               out_run_end
);

  localparam int CW = $clog2(MAX_BODIES + 1);
  localparam int IW = $clog2(MAX_BODIES);

  back_state_t state_r, state_nxt;
  back_ctl_t   ctl;

  logic [CW-1:0] run_cnt;
  logic          run_bank;
  logic [IW-1:0] i_r, j_r;

  logic signed [COORD_W:0]   d_r   [3];
  logic signed [COORD_W-1:0] mid_r [3];
  logic [COORD_W-1:0]        rsum_r;
  logic [COORD_W-1:0]        mag_d [3];
  logic [RAD_W-1:0]          e_v   [3];
  logic                      phase_r, k_r;
  logic [1:0]                ax_r;
  logic [63:0]               prod_r, r2_r;
  logic [65:0]               acc_r;
  logic [COORD_W-1:0]        op;
  logic [RAD_W-1:0]          e_sel;
  logic                      neg_sel;

  logic [63:0] rem_r, res_r, bitv;
  logic [64:0] trial;
  logic [4:0]  it_r;
  logic        sq_ok;

  logic [COORD_W-1:0] m_r, drem_r;
  logic [QUO_W-1:0]   nlo_r, q_r, q_nxt, q_cl;
  logic [3:0]         dit_r;
  logic [COORD_W:0]   rem_sh;
  logic               dge;
  logic [45:0]        num;
  logic [NRM_W-1:0]   qe;
  logic signed [NRM_W-1:0] nrm_r [3];
  logic               coin_r, contact, all_zero, out_free;

  logic signed [COORD_W:0] sum_mid [3];
  logic signed [COORD_W:0] d_new   [3];
  logic [CW-1:0] i_ext, j_ext;

  assign run_cnt  = q_head[CW-1:0];
  assign run_bank = q_head[CW];
  assign raddr_a  = {run_bank, i_r};
  assign raddr_b  = {run_bank, j_r};
  assign out_free = !out_valid || out_ready;
  assign q_pop    = ctl.q_pop;
  assign i_ext    = CW'(i_r);
  assign j_ext    = CW'(j_r);

  // Difference and midpoint of the two centres just read.
  always_comb begin
    d_new[0]   = {rdata_a.x[COORD_W-1], rdata_a.x} - {rdata_b.x[COORD_W-1], rdata_b.x};
    d_new[1]   = {rdata_a.y[COORD_W-1], rdata_a.y} - {rdata_b.y[COORD_W-1], rdata_b.y};
    d_new[2]   = {rdata_a.z[COORD_W-1], rdata_a.z} - {rdata_b.z[COORD_W-1], rdata_b.z};
    sum_mid[0] = {rdata_a.x[COORD_W-1], rdata_a.x} + {rdata_b.x[COORD_W-1], rdata_b.x};
    sum_mid[1] = {rdata_a.y[COORD_W-1], rdata_a.y} + {rdata_b.y[COORD_W-1], rdata_b.y};
    sum_mid[2] = {rdata_a.z[COORD_W-1], rdata_a.z} + {rdata_b.z[COORD_W-1], rdata_b.z};
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag_d[a] = mag33(d_r[a]);
      e_v[a]   = RAD_W'(mag_d[a] >> k_r);
    end
    case (ax_r)
      2'd0: begin e_sel = e_v[0]; neg_sel = d_r[0][COORD_W]; end
      2'd1: begin e_sel = e_v[1]; neg_sel = d_r[1][COORD_W]; end
      2'd2: begin e_sel = e_v[2]; neg_sel = d_r[2][COORD_W]; end
      default: begin e_sel = '0; neg_sel = 1'b0; end
    endcase
    if (phase_r) begin
      op = {1'b0, e_sel};
    end else begin
      case (ax_r)
        2'd0:    op = mag_d[0];
        2'd1:    op = mag_d[1];
        2'd2:    op = mag_d[2];
        default: op = rsum_r;
      endcase
    end
    all_zero = (d_r[0] == '0) && (d_r[1] == '0) && (d_r[2] == '0);
    contact  = (acc_r < {2'b00, r2_r});
    // One step of the bitwise integer square root.
    bitv  = 64'h4000_0000_0000_0000 >> {it_r, 1'b0};
    trial = {1'b0, res_r} + {1'b0, bitv};
    sq_ok = ({1'b0, rem_r} >= trial);
    // One step of the restoring division.
    rem_sh = {drem_r, nlo_r[QUO_W-1]};
    dge    = (rem_sh >= {1'b0, m_r});
    q_nxt  = {q_r[QUO_W-2:0], dge};
    q_cl   = (q_nxt > NORM_ONE) ? NORM_ONE : q_nxt;
    qe     = {1'b0, q_cl};
    num    = {1'b0, e_sel, 14'd0} + 46'(m_r >> 1);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:  if (!q_stat.empty) state_nxt = (run_cnt < CW'(2)) ? BK_CLOSE : BK_READ;
      BK_READ:  state_nxt = BK_DIFF;
      BK_DIFF:  state_nxt = (rdata_a.part && rdata_b.part) ? BK_MUL : BK_NEXT;
      BK_MUL:   state_nxt = BK_ACC;
      BK_ACC: begin
        if (!phase_r) state_nxt = (ax_r == 2'd3) ? BK_TEST : BK_MUL;
        else          state_nxt = (ax_r == 2'd2) ? BK_SQRT : BK_MUL;
      end
      BK_TEST: begin
        if (!contact)     state_nxt = BK_NEXT;
        else if (all_zero) state_nxt = BK_EMIT;
        else              state_nxt = BK_MUL;
      end
      BK_SQRT:  if (it_r == 5'd31) state_nxt = BK_DIVI;
      BK_DIVI:  state_nxt = BK_DIV;
      BK_DIV:   if (dit_r == 4'(QUO_W - 1)) state_nxt = (ax_r == 2'd2) ? BK_EMIT : BK_DIVI;
      BK_EMIT:  if (out_free) state_nxt = BK_NEXT;
      BK_NEXT: begin
        if (j_ext + 1'b1 < run_cnt || i_ext + CW'(2) < run_cnt) state_nxt = BK_READ;
        else state_nxt = BK_CLOSE;
      end
      BK_CLOSE: if (out_free) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    ctl = '0;
    case (state_r)
      BK_EMIT:  ctl.ld_out = out_free;
      BK_CLOSE: begin
        ctl.ld_out  = out_free;
        ctl.out_end = 1'b1;
        ctl.q_pop   = out_free;
      end
      default:  ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctl.ld_out)     out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end

    case (state_r)
      BK_IDLE: begin
        i_r <= '0;
        j_r <= IW'(1);
      end
      BK_DIFF: begin
        for (int a = 0; a < 3; a++) begin
          d_r[a]   <= d_new[a];
          mid_r[a] <= sum_mid[a][COORD_W:1];
        end
        rsum_r  <= {1'b0, rdata_a.r} + {1'b0, rdata_b.r};
        acc_r   <= '0;
        ax_r    <= '0;
        phase_r <= 1'b0;
        coin_r  <= 1'b0;
      end
      BK_MUL: prod_r <= op * op;
      BK_ACC: begin
        if (!phase_r && ax_r == 2'd3) begin
          r2_r <= prod_r;
        end else begin
          acc_r <= acc_r + {2'b00, prod_r};
          ax_r  <= ax_r + 1'b1;
        end
        rem_r <= acc_r[63:0] + prod_r;
        res_r <= '0;
        it_r  <= '0;
      end
      BK_TEST: begin
        coin_r  <= all_zero;
        k_r     <= mag_d[0][COORD_W-1] | mag_d[1][COORD_W-1] | mag_d[2][COORD_W-1];
        phase_r <= 1'b1;
        ax_r    <= '0;
        acc_r   <= '0;
        for (int a = 0; a < 3; a++) begin
          nrm_r[a] <= '0;
        end
      end
      BK_SQRT: begin
        if (sq_ok) begin
          rem_r <= rem_r - trial[63:0];
          res_r <= (res_r >> 1) + bitv;
        end else begin
          res_r <= res_r >> 1;
        end
        it_r <= it_r + 1'b1;
        ax_r <= '0;
      end
      BK_DIVI: begin
        if (m_r != res_r[COORD_W-1:0] && ax_r == 2'd0) begin
          m_r <= res_r[COORD_W-1:0];
        end
        drem_r <= {1'b0, num[45:QUO_W]};
        nlo_r  <= num[QUO_W-1:0];
        q_r    <= '0;
        dit_r  <= '0;
      end
      BK_DIV: begin
        drem_r <= dge ? rem_sh[COORD_W-1:0] - m_r : rem_sh[COORD_W-1:0];
        nlo_r  <= {nlo_r[QUO_W-2:0], 1'b0};
        q_r    <= q_nxt;
        dit_r  <= dit_r + 1'b1;
        if (dit_r == 4'(QUO_W - 1)) begin
          case (ax_r)
            2'd0:    nrm_r[0] <= neg_sel ? NRM_W'(16'd0 - qe) : qe;
            2'd1:    nrm_r[1] <= neg_sel ? NRM_W'(16'd0 - qe) : qe;
            default: nrm_r[2] <= neg_sel ? NRM_W'(16'd0 - qe) : qe;
          endcase
          ax_r <= ax_r + 1'b1;
        end
      end
      BK_NEXT: begin
        if (j_ext + 1'b1 < run_cnt) begin
          j_r <= j_r + 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
          j_r <= i_r + IW'(2);
        end
      end
      default: ;
    endcase

    // The partial root before the last step can exceed 32 bits, so the final
    // shift works on the full register.
    if (state_r == BK_SQRT && it_r == 5'd31) begin
      m_r <= sq_ok ? COORD_W'((res_r >> 1) + bitv) : COORD_W'(res_r >> 1);
    end

    if (ctl.ld_out) begin
      out_contact_valid <= !ctl.out_end;
      out_run_end       <= ctl.out_end;
      out_first_index   <= ctl.out_end ? '0 : IDX_OUT_W'(i_r);
      out_second_index  <= ctl.out_end ? '0 : IDX_OUT_W'(j_r);
      out_point_x       <= ctl.out_end ? '0 : mid_r[0];
      out_point_y       <= ctl.out_end ? '0 : mid_r[1];
      out_point_z       <= ctl.out_end ? '0 : mid_r[2];
      out_normal_x      <= ctl.out_end ? '0 : nrm_r[0];
      out_normal_y      <= ctl.out_end ? '0 : nrm_r[1];
      out_normal_z      <= ctl.out_end ? '0 : nrm_r[2];
      out_coincident    <= ctl.out_end ? 1'b0 : coin_r;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sphere_pair_broad_phase.sv
// Flow: each body is written to the current bank as it is taken. After the last body the
// run reads each pair, skips it if a body sits out, else squares and tests distance and
// reach; a contact with distinct centers adds a 32-step square root and three divisions
// before its emit, coincident centers are emitted directly, and a closing item ends it.
// Throughput: bodies stream at one per cycle while a run is processed in the other bank;
// intake stalls while one run is in progress and another is already queued. Reset clears
// control state, the body count and the run queue; stored bodies are not cleared.
`default_nettype none
module sphere_pair_broad_phase
  import spbp_pkg::*;
#(
  parameter int MAX_BODIES = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [COORD_W-1:0] in_pos_x,
  input  wire logic signed [COORD_W-1:0] in_pos_y,
  input  wire logic signed [COORD_W-1:0] in_pos_z,
  input  wire logic [RAD_W-1:0]          in_bound_radius,
  input  wire logic                      in_is_rigid,
  input  wire logic                      in_collidable,
  input  wire logic                      in_last_body,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_contact_valid,
  output logic [IDX_OUT_W-1:0]           out_first_index,
  output logic [IDX_OUT_W-1:0]           out_second_index,
  output logic signed [COORD_W-1:0]      out_point_x,
  output logic signed [COORD_W-1:0]      out_point_y,
  output logic signed [COORD_W-1:0]      out_point_z,
  output logic signed [NRM_W-1:0]        out_normal_x,
  output logic signed [NRM_W-1:0]        out_normal_y,
  output logic signed [NRM_W-1:0]        out_normal_z,
  output logic                           out_coincident,
  output logic                           out_run_end
);

  // The body memory holds two banks so the front end can fill one set while the
  // back end works through the previous one. A queue entry names the bank and the
  // number of bodies stored for one run.
  localparam int AW = $clog2(2 * MAX_BODIES);
  localparam int QW = $clog2(MAX_BODIES + 1) + 1;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, raddr_a, raddr_b;
  body_t         ram_wdata, rdata_a, rdata_b;
  logic          q_push, q_pop;
  logic [QW-1:0] q_data, q_head;
  q_stat_t       q_stat;

  spbp_front #(.MAX_BODIES(MAX_BODIES)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_pos_x, .in_pos_y, .in_pos_z,
    .in_bound_radius, .in_is_rigid, .in_collidable, .in_last_body,
    .ram_we, .ram_waddr, .ram_wdata, .q_push, .q_data, .q_stat
  );

  spbp_queue #(.WIDTH(QW), .DEPTH(2)) u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_data), .pop(q_pop),
    .head(q_head), .stat(q_stat)
  );

  // The bank bit sits above the body index, so the memory spans the full address range.
  spbp_ram #(.WIDTH($bits(body_t)), .DEPTH(1 << AW)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr_a, .raddr_b, .rdata_a, .rdata_b
  );

  // Each contact transaction carries the pair indices, the midpoint and the unit
  // normal; a closing transaction with run_end set ends every run.
  spbp_back #(.MAX_BODIES(MAX_BODIES)) u_back (
    .clk, .rst_n, .q_head, .q_stat, .q_pop, .raddr_a, .raddr_b, .rdata_a, .rdata_b,
    .out_valid, .out_ready, .out_contact_valid, .out_first_index, .out_second_index,
    .out_point_x, .out_point_y, .out_point_z, .out_normal_x, .out_normal_y,
    .out_normal_z, .out_coincident, .out_run_end
  );

endmodule
`default_nettype wire

// File: bench/spbp_checker.sv
// Scoreboard for the sphere pair broad phase: models the block and compares its output.
`timescale 1ns / 100ps
module spbp_checker
  import spbp_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic                      in_ready,
  input  wire logic signed [COORD_W-1:0] in_pos_x,
  input  wire logic signed [COORD_W-1:0] in_pos_y,
  input  wire logic signed [COORD_W-1:0] in_pos_z,
  input  wire logic [RAD_W-1:0]          in_bound_radius,
  input  wire logic                      in_is_rigid,
  input  wire logic                      in_collidable,
  input  wire logic                      in_last_body,
  input  wire logic                      out_valid,
  input  wire logic                      out_ready,
  input  wire logic                      out_contact_valid,
  input  wire logic [IDX_OUT_W-1:0]      out_first_index,
  input  wire logic [IDX_OUT_W-1:0]      out_second_index,
  input  wire logic signed [COORD_W-1:0] out_point_x,
  input  wire logic signed [COORD_W-1:0] out_point_y,
  input  wire logic signed [COORD_W-1:0] out_point_z,
  input  wire logic signed [NRM_W-1:0]   out_normal_x,
  input  wire logic signed [NRM_W-1:0]   out_normal_y,
  input  wire logic signed [NRM_W-1:0]   out_normal_z,
  input  wire logic                      out_coincident,
  input  wire logic                      out_run_end,
  output int                             mismatches,
  output int                             outstanding,
  output int                             contacts_seen
);

  localparam int BODY_SLOTS = 8;
  localparam longint UNIT_NORMAL = 16384;

  typedef struct packed {
    logic                      contact;
    logic [IDX_OUT_W-1:0]      first;
    logic [IDX_OUT_W-1:0]      second;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic signed [NRM_W-1:0]   nx;
    logic signed [NRM_W-1:0]   ny;
    logic signed [NRM_W-1:0]   nz;
    logic                      coinc;
    logic                      last;
  } contact_rec_t;

  contact_rec_t pending_contacts[$];

  longint     pos_mem[BODY_SLOTS][3];
  logic [RAD_W-1:0] rad_mem[BODY_SLOTS];
  bit         part_mem[BODY_SLOTS];
  int         stored;

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Floor of the exact average, done on an offset so the shift stays unsigned.
  function automatic logic [COORD_W-1:0] center_of(longint a, longint b);
    logic [63:0] s;
    s = a + b + 64'h1_0000_0000;
    return (s >> 1) - 64'h8000_0000;
  endfunction

  task automatic collide_set();
    contact_rec_t rec;
    longint       d[3];
    logic [63:0]  mg[3];
    logic [63:0]  e[3];
    logic [127:0] dist2;
    logic [127:0] reach2;
    logic [63:0]  reach;
    logic [63:0]  mx;
    logic [63:0]  acc;
    logic [63:0]  m;
    logic [63:0]  q;
    int           k;
    for (int i = 0; i < stored; i++) begin
      if (!part_mem[i]) continue;
      for (int j = i + 1; j < stored; j++) begin
        if (!part_mem[j]) continue;
        dist2 = 0;
        mx = 0;
        for (int a = 0; a < 3; a++) begin
          d[a]  = pos_mem[i][a] - pos_mem[j][a];
          mg[a] = abs64(d[a]);
          dist2 = dist2 + {64'd0, mg[a]} * {64'd0, mg[a]};
          if (mg[a] > mx) mx = mg[a];
        end
        reach  = {33'd0, rad_mem[i]} + {33'd0, rad_mem[j]};
        reach2 = {64'd0, reach} * {64'd0, reach};
        if (dist2 >= reach2) continue;
        rec = '0;
        rec.contact = 1'b1;
        rec.first   = i[IDX_OUT_W-1:0];
        rec.second  = j[IDX_OUT_W-1:0];
        rec.px = center_of(pos_mem[i][0], pos_mem[j][0]);
        rec.py = center_of(pos_mem[i][1], pos_mem[j][1]);
        rec.pz = center_of(pos_mem[i][2], pos_mem[j][2]);
        if (mx == 0) begin
          rec.coinc = 1'b1;
        end else begin
          // Prescale so that each squared component fits the square root width.
          k = 0;
          while ((mx >> k) >= 64'h8000_0000) k++;
          acc = 0;
          for (int a = 0; a < 3; a++) begin
            e[a] = mg[a] >> k;
            acc  = acc + e[a] * e[a];
          end
          m = int_sqrt(acc);
          for (int a = 0; a < 3; a++) begin
            q = (e[a] * UNIT_NORMAL + (m >> 1)) / m;
            if (q > UNIT_NORMAL) q = UNIT_NORMAL;
            if (d[a] < 0) q = -q;
            case (a)
              0: rec.nx = q[NRM_W-1:0];
              1: rec.ny = q[NRM_W-1:0];
              default: rec.nz = q[NRM_W-1:0];
            endcase
          end
        end
        pending_contacts.push_back(rec);
      end
    end
    rec = '0;
    rec.last = 1'b1;
    pending_contacts.push_back(rec);
    stored = 0;
  endtask

  contact_rec_t got;
  contact_rec_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      stored        = 0;
      mismatches    = 0;
      contacts_seen = 0;
      pending_contacts.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (stored < BODY_SLOTS) begin
          pos_mem[stored][0] = in_pos_x;
          pos_mem[stored][1] = in_pos_y;
          pos_mem[stored][2] = in_pos_z;
          rad_mem[stored]    = in_bound_radius;
          part_mem[stored]   = in_is_rigid && in_collidable;
          stored++;
        end
        if (in_last_body) collide_set();
      end
      if (out_valid && out_ready) begin
        got = {out_contact_valid, out_first_index, out_second_index, out_point_x,
               out_point_y, out_point_z, out_normal_x, out_normal_y, out_normal_z,
               out_coincident, out_run_end};
        if (out_contact_valid) contacts_seen++;
        if (pending_contacts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result transaction %p", $realtime, got);
        end else begin
          want = pending_contacts.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected %p", want);
              $display("  actual   %p", got);
            end
          end
        end
      end
    end
    outstanding = pending_contacts.size();
  end

endmodule

// File: bench/tb_sphere_pair_broad_phase.sv
// Stimulus and verdict for the sphere pair broad phase block.
`timescale 1ns / 100ps
module tb_sphere_pair_broad_phase
  import spbp_pkg::*;
;

  localparam int STALL_LIMIT = 20000;
  localparam int ITEMS_PER_PHASE = 100;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [COORD_W-1:0] in_pos_x;
  logic signed [COORD_W-1:0] in_pos_y;
  logic signed [COORD_W-1:0] in_pos_z;
  logic [RAD_W-1:0]          in_bound_radius;
  logic                      in_is_rigid;
  logic                      in_collidable;
  logic                      in_last_body;
  logic                      out_valid;
  logic                      out_ready;
  logic                      out_contact_valid;
  logic [IDX_OUT_W-1:0]      out_first_index;
  logic [IDX_OUT_W-1:0]      out_second_index;
  logic signed [COORD_W-1:0] out_point_x;
  logic signed [COORD_W-1:0] out_point_y;
  logic signed [COORD_W-1:0] out_point_z;
  logic signed [NRM_W-1:0]   out_normal_x;
  logic signed [NRM_W-1:0]   out_normal_y;
  logic signed [NRM_W-1:0]   out_normal_z;
  logic                      out_coincident;
  logic                      out_run_end;

  int mismatches;
  int outstanding;
  int contacts_seen;

  // Idle percentages of each side; the stimulus walks them through three phases.
  int send_idle_pct;
  int recv_idle_pct;
  int bodies_sent;
  int sets_sent;
  int quiet_cycles;

  sphere_pair_broad_phase u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_bound_radius  (in_bound_radius),
    .in_is_rigid      (in_is_rigid),
    .in_collidable    (in_collidable),
    .in_last_body     (in_last_body),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_contact_valid(out_contact_valid),
    .out_first_index  (out_first_index),
    .out_second_index (out_second_index),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_point_z      (out_point_z),
    .out_normal_x     (out_normal_x),
    .out_normal_y     (out_normal_y),
    .out_normal_z     (out_normal_z),
    .out_coincident   (out_coincident),
    .out_run_end      (out_run_end)
  );

  spbp_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_bound_radius  (in_bound_radius),
    .in_is_rigid      (in_is_rigid),
    .in_collidable    (in_collidable),
    .in_last_body     (in_last_body),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_contact_valid(out_contact_valid),
    .out_first_index  (out_first_index),
    .out_second_index (out_second_index),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_point_z      (out_point_z),
    .out_normal_x     (out_normal_x),
    .out_normal_y     (out_normal_y),
    .out_normal_z     (out_normal_z),
    .out_coincident   (out_coincident),
    .out_run_end      (out_run_end),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .contacts_seen    (contacts_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side drops ready at random; the pattern changes with the phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: a long stretch with no transaction on either channel means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("tb_sphere_pair_broad_phase NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one body and returns at the edge where the transaction completes. Valid is
  // only dropped while idling, so back-to-back bodies keep it high without a glitch.
  task automatic offer_body(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz, input logic [RAD_W-1:0] rad,
                            input bit rigid, input bit coll, input bit last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_pos_x        <= px;
    in_pos_y        <= py;
    in_pos_z        <= pz;
    in_bound_radius <= rad;
    in_is_rigid     <= rigid;
    in_collidable   <= coll;
    in_last_body    <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bodies_sent++;
    if (last) sets_sent++;
  endtask

  // A well-formed set: bodies scattered around one center at a random scale, with
  // radii of about the same scale so that a fair share of the pairs touch.
  task automatic clustered_set(input int count);
    logic [31:0] cx, cy, cz;
    int          spread;
    bit          part;
    cx = $urandom;
    cy = $urandom;
    cz = $urandom;
    spread = $urandom_range(2, 30);
    for (int n = 0; n < count; n++) begin
      part = ($urandom_range(0, 99) < 85);
      offer_body(cx + ($signed($urandom) >>> (31 - spread)),
                 cy + ($signed($urandom) >>> (31 - spread)),
                 cz + ($signed($urandom) >>> (31 - spread)),
                 $urandom >> (32 - spread),
                 part || $urandom_range(0, 1), part || $urandom_range(0, 1),
                 n == count - 1);
    end
  endtask

  // Noise: fully random fields, including last markers at arbitrary places.
  task automatic noise_body();
    offer_body($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1),
               $urandom_range(0, 1), $urandom_range(0, 4) == 0);
  endtask

  task automatic random_phase(input int s_idle, input int r_idle);
    int goal;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    goal = bodies_sent + ITEMS_PER_PHASE;
    while (bodies_sent < goal) begin
      case ($urandom_range(0, 9))
        0:       noise_body();
        1:       clustered_set($urandom_range(9, 10));
        2:       clustered_set(1);
        default: clustered_set($urandom_range(2, 8));
      endcase
    end
    // Close any set that noise left open so the phase ends with a run.
    offer_body($urandom, $urandom, $urandom, $urandom, 1'b1, 1'b1, 1'b1);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_pos_x        = '0;
    in_pos_y        = '0;
    in_pos_z        = '0;
    in_bound_radius = '0;
    in_is_rigid     = 1'b0;
    in_collidable   = 1'b0;
    in_last_body    = 1'b0;
    out_ready       = 1'b0;
    send_idle_pct   = 29;
    recv_idle_pct   = 70;
    bodies_sent     = 0;
    sets_sent       = 0;
    quiet_cycles    = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a set made only of its last body, then opposite corners of the
    // coordinate range with the widest radii (far apart, no contact).
    offer_body(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 31'h0001_0000, 1, 1, 1);
    offer_body(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 1, 1, 0);
    offer_body(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1, 1, 1);
    // Extremes on one axis only; the largest difference forces the prescale.
    offer_body(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF, 1, 1, 0);
    offer_body(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF, 1, 1, 1);
    // Coincident centers, plus a touching neighbor and bodies that sit out.
    offer_body(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 31'h0000_0001, 1, 1, 0);
    offer_body(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 31'h0000_0001, 1, 1, 0);
    offer_body(32'h0001_0001, 32'hFFFF_0000, 32'h0000_8000, 31'h0000_0001, 0, 1, 0);
    offer_body(32'h0001_0001, 32'hFFFF_0000, 32'h0000_8000, 31'h0000_0001, 1, 0, 0);
    offer_body(32'h0001_0003, 32'hFFFF_0001, 32'h0000_8000, 31'h0000_0004, 1, 1, 1);
    // A pair exactly at touching distance is not a contact.
    offer_body(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 31'h0000_0002, 1, 1, 0);
    offer_body(32'h0000_0005, 32'h0000_0000, 32'h0000_0000, 31'h0000_0003, 1, 1, 1);
    // Ten bodies: the list fills at eight and the last two are dropped.
    for (int n = 0; n < 10; n++)
      offer_body(n * 3, -n, n, 31'h0000_0010, 1, 1, n == 9);
    // A set where every body sits out.
    offer_body(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF, 0, 0, 0);
    offer_body(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF, 0, 1, 1);

    random_phase(29, 70);
    random_phase(70, 29);
    random_phase(0, 0);
    in_valid <= 1'b0;

    // Let the checker take in the final body before looking at what is still due.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d bodies in %0d sets; %0d contacts were returned and checked.",
             bodies_sent, sets_sent, contacts_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_sphere_pair_broad_phase OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, outstanding);
      $display("tb_sphere_pair_broad_phase NOT OK");
    end
    $finish;
  end

endmodule
